[src/tpjv_pkg.sv]
// Package for the touch pad and jog qualifier: pad indexes, register map,
// reset values and default sample width. No dependencies.
`default_nettype none

package tpjv_pkg;

    localparam int unsigned SAMPLE_BITS_DEF = 16;

    localparam int unsigned PAD_COUNT = 6;
    localparam int unsigned JOG_COUNT = 4;

    // pad order matches the counter store: four jog pads, then the valve pads
    localparam int unsigned PAD_LEFT  = 0;
    localparam int unsigned PAD_RIGHT = 1;
    localparam int unsigned PAD_UP    = 2;
    localparam int unsigned PAD_DOWN  = 3;
    localparam int unsigned PAD_CLOSE = 4;
    localparam int unsigned PAD_OPEN  = 5;

    localparam int unsigned READ_W  = 16;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    localparam logic [READ_W-1:0] THRESHOLD_RST = 16'd20;
    localparam logic [CNT_W-1:0]  HOLD_RST      = 4'd10;
    localparam logic [CNT_W-1:0]  CNT_MAX       = 4'd15;

    typedef enum logic {
        REG_PRESS_THRESHOLD = 1'b0,
        REG_HOLD_COUNT      = 1'b1
    } t_reg_idx;

    typedef logic [CNT_W-1:0] t_cnt;

endpackage

`default_nettype wire

[src/touch_pad_jog_valve_qualifier.sv]
// Touch pad and jog qualifier top level: input register, qualification
// logic and result register, with an APB-style register port. Uses tpjv_pkg.
//
// One scan word is accepted per clock cycle: the scan is captured in an input
// register, then the six pad compares and counter updates run in one pass into
// the result register. The throughput of one word per cycle is set by that
// single-pass update of the counter state; both stages stall only when the
// result register is full and not taken.
// Readings keep their low SAMPLE_BITS bits. Write configuration only while idle.
`default_nettype none

module touch_pad_jog_valve_qualifier #(
    parameter int unsigned SAMPLE_BITS = tpjv_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tpjv_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [tpjv_pkg::DATA_W-1:0]  pwdata,
    output      logic [tpjv_pkg::DATA_W-1:0]  prdata,
    output      logic                         pready,

    input  wire logic                         i_in_valid,
    output      logic                         o_in_ready,
    input  wire logic [tpjv_pkg::READ_W-1:0]  i_touch_left,
    input  wire logic [tpjv_pkg::READ_W-1:0]  i_touch_right,
    input  wire logic [tpjv_pkg::READ_W-1:0]  i_touch_up,
    input  wire logic [tpjv_pkg::READ_W-1:0]  i_touch_down,
    input  wire logic [tpjv_pkg::READ_W-1:0]  i_touch_close,
    input  wire logic [tpjv_pkg::READ_W-1:0]  i_touch_open,
    input  wire logic                         i_jog_left,
    input  wire logic                         i_jog_right,
    input  wire logic                         i_jog_up,
    input  wire logic                         i_jog_down,

    output      logic                         o_out_valid,
    input  wire logic                         i_out_ready,
    output      logic                         o_step_left,
    output      logic                         o_step_right,
    output      logic                         o_step_up,
    output      logic                         o_step_down,
    output      logic                         o_valve_open
);
    import tpjv_pkg::*;

    // configuration
    logic [READ_W-1:0] r_threshold;
    t_cnt              r_hold;
    t_reg_idx          w_idx;
    logic              w_wr;

    // input stage
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_touch [PAD_COUNT];
    logic [JOG_COUNT-1:0]   r_jog;

    // state
    t_cnt r_cnt [PAD_COUNT];
    logic r_valve;

    // result stage
    logic                 r_out_valid;
    logic [JOG_COUNT-1:0] r_step;
    logic                 r_out_valve;

    logic                 w_adv;
    logic                 w_load;
    t_cnt                 n_cnt [PAD_COUNT];
    logic [PAD_COUNT-1:0] w_act;
    logic                 n_valve;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        unique case (w_idx)
            REG_PRESS_THRESHOLD: prdata = DATA_W'(r_threshold);
            REG_HOLD_COUNT:      prdata = DATA_W'(r_hold);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_hold      <= HOLD_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PRESS_THRESHOLD: r_threshold <= pwdata[READ_W-1:0];
                REG_HOLD_COUNT:      r_hold      <= pwdata[CNT_W-1:0];
                default:             ;
            endcase
        end
    end

    // advance the result stage when it is empty or being taken
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_load     = r_s1_valid && w_adv;
    assign o_in_ready = !r_s1_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_touch[PAD_LEFT]  <= i_touch_left[SAMPLE_BITS-1:0];
            r_touch[PAD_RIGHT] <= i_touch_right[SAMPLE_BITS-1:0];
            r_touch[PAD_UP]    <= i_touch_up[SAMPLE_BITS-1:0];
            r_touch[PAD_DOWN]  <= i_touch_down[SAMPLE_BITS-1:0];
            r_touch[PAD_CLOSE] <= i_touch_close[SAMPLE_BITS-1:0];
            r_touch[PAD_OPEN]  <= i_touch_open[SAMPLE_BITS-1:0];
            r_jog <= {i_jog_down, i_jog_up, i_jog_right, i_jog_left};
        end
    end

    always_comb begin
        logic [READ_W-1:0]    v;
        logic                 jog;
        logic                 pressed;
        logic [PAD_COUNT-1:0] jog_all;
        // valve pads have no jog flag
        jog_all = PAD_COUNT'(r_jog);
        for (int i = 0; i < PAD_COUNT; i++) begin
            v       = READ_W'(r_touch[i]);
            jog     = jog_all[i];
            pressed = (v < r_threshold) || jog;
            w_act[i] = 1'b0;
            n_cnt[i] = r_cnt[i];
            if (pressed) begin
                if ((r_cnt[i] > r_hold) || jog) begin
                    w_act[i] = 1'b1;
                end else if (r_cnt[i] != CNT_MAX) begin
                    n_cnt[i] = r_cnt[i] + t_cnt'(1);
                end
            end else begin
                n_cnt[i] = '0;
            end
        end
        // close wins over open
        n_valve = r_valve;
        if (w_act[PAD_OPEN]) begin
            n_valve = 1'b1;
        end
        if (w_act[PAD_CLOSE]) begin
            n_valve = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAD_COUNT; i++) begin
                r_cnt[i] <= '0;
            end
            r_valve <= 1'b0;
        end else if (w_load) begin
            for (int i = 0; i < PAD_COUNT; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
            r_valve <= n_valve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_step      <= w_act[JOG_COUNT-1:0];
            r_out_valve <= n_valve;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_step_left  = r_step[PAD_LEFT];
    assign o_step_right = r_step[PAD_RIGHT];
    assign o_step_up    = r_step[PAD_UP];
    assign o_step_down  = r_step[PAD_DOWN];
    assign o_valve_open = r_out_valve;

endmodule

`default_nettype wire

[sim/touch_pad_jog_valve_qualifier_tb.sv]
// Self-checking testbench for the touch pad and jog qualifier: directed and random
// scans with random gaps and stalls, checked against an in-bench predictor.
// Depends on tpjv_pkg and touch_pad_jog_valve_qualifier.
`timescale 1ns / 100ps

module touch_pad_jog_valve_qualifier_tb;
    import tpjv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [PAD_COUNT-1:0][READ_W-1:0] touch;
        logic [JOG_COUNT-1:0]             jog;
    } t_scan;

    typedef struct packed {
        logic step_left;
        logic step_right;
        logic step_up;
        logic step_down;
        logic valve_open;
    } t_qual;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic                             scan_valid = 1'b0;
    logic                             o_in_ready;
    logic [PAD_COUNT-1:0][READ_W-1:0] pad_reading = '0;
    logic [JOG_COUNT-1:0]             jog_flags = '0;

    logic o_out_valid;
    logic out_ready = 1'b0;
    logic o_step_left, o_step_right, o_step_up, o_step_down, o_valve_open;

    // predictor state and its copy of the registers
    logic [READ_W-1:0] press_thr;
    logic [CNT_W-1:0]  hold_lim;
    t_cnt              press_runs [PAD_COUNT];
    logic              valve_q;

    t_qual expected_quals [$];
    bit    idle_on = 1'b1;
    bit    pad_held [PAD_COUNT];
    int    flip_pct = 6;
    int    jog_pct = 12;
    int    err_count = 0;
    int    idle_cycles = 0;

    touch_pad_jog_valve_qualifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (scan_valid),
        .o_in_ready    (o_in_ready),
        .i_touch_left  (pad_reading[PAD_LEFT]),
        .i_touch_right (pad_reading[PAD_RIGHT]),
        .i_touch_up    (pad_reading[PAD_UP]),
        .i_touch_down  (pad_reading[PAD_DOWN]),
        .i_touch_close (pad_reading[PAD_CLOSE]),
        .i_touch_open  (pad_reading[PAD_OPEN]),
        .i_jog_left    (jog_flags[PAD_LEFT]),
        .i_jog_right   (jog_flags[PAD_RIGHT]),
        .i_jog_up      (jog_flags[PAD_UP]),
        .i_jog_down    (jog_flags[PAD_DOWN]),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_step_left   (o_step_left),
        .o_step_right  (o_step_right),
        .o_step_up     (o_step_up),
        .o_step_down   (o_step_down),
        .o_valve_open  (o_valve_open)
    );

    always #5 i_clk = ~i_clk;

    function automatic void reset_predictor();
        press_thr = THRESHOLD_RST;
        hold_lim  = HOLD_RST;
        for (int p = 0; p < PAD_COUNT; p++) begin
            press_runs[p] = '0;
        end
        valve_q = 1'b0;
    endfunction

    // Advance one pad's press run; return 1 when the pad acts in this scan.
    function automatic logic qualify_pad(input int unsigned pad, input logic [READ_W-1:0] reading,
                                         input logic jog);
        if (!(reading < press_thr || jog)) begin
            press_runs[pad] = '0;
            return 1'b0;
        end
        if (press_runs[pad] > hold_lim || jog) begin
            return 1'b1;
        end
        if (press_runs[pad] != CNT_MAX) begin
            press_runs[pad] = press_runs[pad] + t_cnt'(1);
        end
        return 1'b0;
    endfunction

    function automatic t_qual qualify_scan(input t_scan s);
        t_qual q;
        q.step_left  = qualify_pad(PAD_LEFT, s.touch[PAD_LEFT], s.jog[PAD_LEFT]);
        q.step_right = qualify_pad(PAD_RIGHT, s.touch[PAD_RIGHT], s.jog[PAD_RIGHT]);
        q.step_up    = qualify_pad(PAD_UP, s.touch[PAD_UP], s.jog[PAD_UP]);
        q.step_down  = qualify_pad(PAD_DOWN, s.touch[PAD_DOWN], s.jog[PAD_DOWN]);
        // open first, close second: close wins
        if (qualify_pad(PAD_OPEN, s.touch[PAD_OPEN], 1'b0)) begin
            valve_q = 1'b1;
        end
        if (qualify_pad(PAD_CLOSE, s.touch[PAD_CLOSE], 1'b0)) begin
            valve_q = 1'b0;
        end
        q.valve_open = valve_q;
        return q;
    endfunction

    function automatic t_scan make_scan(input logic [READ_W-1:0] l, r, u, d, c, o,
                                        input logic [JOG_COUNT-1:0] j);
        t_scan s;
        s.touch[PAD_LEFT]  = l;
        s.touch[PAD_RIGHT] = r;
        s.touch[PAD_UP]    = u;
        s.touch[PAD_DOWN]  = d;
        s.touch[PAD_CLOSE] = c;
        s.touch[PAD_OPEN]  = o;
        s.jog = j;
        return s;
    endfunction

    function automatic logic [READ_W-1:0] pick_reading(input bit want_press);
        int unsigned lim;
        int unsigned r;
        lim = 32'(press_thr);
        r = $urandom_range(99);
        if (r < 5) begin
            return READ_W'($urandom);
        end
        if (want_press && lim != 0) begin
            if (r < 15) return READ_W'(lim - 1);
            if (r < 20) return '0;
            return READ_W'($urandom_range(lim - 1, 0));
        end
        if (r < 15) return READ_W'(lim);
        if (r < 20) return '1;
        return READ_W'($urandom_range(65535, lim));
    endfunction

    // Pads stay pressed or released for runs of scans so that counters reach the hold count.
    function automatic t_scan random_scan();
        t_scan s;
        for (int p = 0; p < PAD_COUNT; p++) begin
            if ($urandom_range(99) < flip_pct) pad_held[p] = !pad_held[p];
            s.touch[p] = pick_reading(pad_held[p]);
        end
        for (int j = 0; j < JOG_COUNT; j++) begin
            s.jog[j] = ($urandom_range(99) < jog_pct);
        end
        return s;
    endfunction

    task automatic send_scan(input t_scan s);
        if (idle_on && $urandom_range(99) < 37) begin
            scan_valid <= 1'b0;
            @(posedge i_clk);
            while (idle_on && $urandom_range(99) < 37) @(posedge i_clk);
        end
        scan_valid  <= 1'b1;
        pad_reading <= s.touch;
        jog_flags   <= s.jog;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_quals.push_back(qualify_scan(s));
    endtask

    // Drop valid, wait for every pending word, then let the pipeline settle.
    task automatic drain_pipe();
        scan_valid <= 1'b0;
        while (expected_quals.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PRESS_THRESHOLD: press_thr = data[READ_W-1:0];
            REG_HOLD_COUNT:      hold_lim  = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic test_default_config();
        send_scan(make_scan('1, '1, '1, '1, '1, '1, 4'b0000));
        send_scan(make_scan(16'd19, 16'd19, 16'd19, 16'd19, 16'd19, 16'd19, 4'b1111));
        send_scan(make_scan(16'd20, 16'd20, 16'd20, 16'd20, 16'd20, 16'd20, 4'b1111));
        send_scan(make_scan('0, '0, '0, '0, '0, '0, 4'b0000));
    endtask

    task automatic test_hold_zero();
        drain_pipe();
        write_reg(REG_HOLD_COUNT, 32'd0);
        send_scan(make_scan('1, '1, '1, '1, '1, '0, 4'b0000));
        send_scan(make_scan('1, '1, '1, '1, '1, '0, 4'b0000));
        send_scan(make_scan('0, '0, '0, '0, '0, '0, 4'b0000));
        send_scan(make_scan('0, '0, '0, '0, '0, '0, 4'b0000));
        send_scan(make_scan('1, '1, '1, '1, '1, '1, 4'b0101));
    endtask

    task automatic test_threshold_extremes();
        drain_pipe();
        write_reg(REG_PRESS_THRESHOLD, 32'd0);
        send_scan(make_scan('0, '0, '0, '0, '0, '0, 4'b0000));
        send_scan(make_scan('0, '0, '0, '0, '0, '0, 4'b1010));
        drain_pipe();
        write_reg(REG_PRESS_THRESHOLD, 32'h0000_FFFF);
        send_scan(make_scan(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 4'b0000));
        send_scan(make_scan(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 4'b0000));
        send_scan(make_scan('1, '1, '1, '1, '1, '1, 4'b0000));
    endtask

    // Hold of fifteen: touch alone never acts, only jog does.
    task automatic test_hold_saturation();
        drain_pipe();
        write_reg(REG_HOLD_COUNT, 32'd15);
        repeat (3) send_scan(make_scan('0, '0, '0, '0, '0, '0, 4'b0000));
        send_scan(make_scan('0, '0, '0, '0, '0, '0, 4'b1111));
    endtask

    task automatic run_random_phase(input logic [READ_W-1:0] thr, input logic [CNT_W-1:0] hold,
                                    input bit idle, input int n);
        drain_pipe();
        idle_on = idle;
        // upper bits of the write data are don't-care
        write_reg(REG_PRESS_THRESHOLD, {16'($urandom), thr});
        write_reg(REG_HOLD_COUNT, {28'($urandom), hold});
        for (int p = 0; p < PAD_COUNT; p++) pad_held[p] = ($urandom_range(1) != 0);
        repeat (n) send_scan(random_scan());
    endtask

    task automatic test_random_scans();
        run_random_phase(THRESHOLD_RST, HOLD_RST, 1'b1, 160);
        run_random_phase(16'd0, CNT_W'($urandom_range(15)), 1'b1, 100);
        run_random_phase(16'hFFFF, 4'd0, 1'b1, 120);
        run_random_phase(READ_W'($urandom_range(65535, 1)), CNT_MAX, 1'b0, 200);
        run_random_phase(READ_W'($urandom_range(65535, 1)), 4'd14, 1'b1, 200);
        run_random_phase(READ_W'($urandom), CNT_W'($urandom_range(15)), 1'b1, 220);
        idle_on = 1'b1;
    endtask

    task automatic compare_bit(input string field, input logic want, input logic got);
        if (got !== want) begin
            $error("%s mismatch: expected %0b, got %0b", field, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        out_ready <= idle_on ? ($urandom_range(99) >= 37) : 1'b1;
    end

    always @(posedge i_clk) begin : check_results
        t_qual want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_quals.size() == 0) begin
                $error("output word with no scan pending");
                err_count++;
            end else begin
                want = expected_quals.pop_front();
                compare_bit("step_left", want.step_left, o_step_left);
                compare_bit("step_right", want.step_right, o_step_right);
                compare_bit("step_up", want.step_up, o_step_up);
                compare_bit("step_down", want.step_down, o_step_down);
                compare_bit("valve_open", want.valve_open, o_valve_open);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (scan_valid && o_in_ready) || (o_out_valid && out_ready)
                || (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        reset_predictor();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_config();
        test_hold_zero();
        test_threshold_extremes();
        test_hold_saturation();
        test_random_scans();
        drain_pipe();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
src/tpjv_pkg.sv
src/touch_pad_jog_valve_qualifier.sv
sim/touch_pad_jog_valve_qualifier_tb.sv
